@@ sv/assert_macros.svh @@
// Assertion macros for the range capture RTL, used by urc_back.
// Expects clk and arst_n in the scope of the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, off while reset is asserted.
`define URC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Condition that must never be seen.
`define URC_ASSERT_NEVER(lbl, cond, msg) \
	`URC_ASSERT(lbl, !(cond), msg)

`endif

@@ sv/urc_pkg.sv @@
// Shared types and constants for the ultrasonic echo range capture block.
// No dependencies.
package urc_pkg;

	localparam logic [31:0] AUTO_RELOAD_RST = 32'd5000000;
	localparam logic [7:0]  CLOCK_MHZ_RST   = 8'd32;
	localparam logic [15:0] PRESCALER_RST   = 16'd9;
	localparam logic [15:0] LIMIT_US_RST    = 16'd11527;

	localparam int unsigned FIFO_DEPTH_DEF = 2;

	// Micrometres of range per microsecond of echo (half the speed of sound).
	localparam logic [7:0] UM_PER_TICK_US = 8'd170;

	// Divider lengths in radix-4 steps.
	localparam logic [4:0] DIV_STEPS_WORD  = 5'd16;
	localparam logic [4:0] DIV_STEPS_TICKS = 5'd4;

	typedef enum logic [1:0] {
		CFG_AUTO_RELOAD = 2'd0,
		CFG_CLOCK_MHZ   = 2'd1,
		CFG_PRESCALER   = 2'd2,
		CFG_LIMIT_US    = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		STATUS_VALID    = 2'd0,
		STATUS_TIMEOUT  = 2'd1,
		STATUS_NO_TICKS = 2'd2
	} status_t;

	typedef struct packed {
		logic        start;
		logic [31:0] dividend;
		logic [16:0] divisor;
		logic [4:0]  steps;
	} div_req_t;

endpackage

@@ sv/urc_in_if.sv @@
// Input channel: timer events (overflow or edge capture) with valid/ready.
// No dependencies.
interface urc_in_if;
	logic        valid;
	logic        ready;
	logic        action;
	logic [31:0] capture_count;

	modport source(output valid, action, capture_count, input ready);
	modport sink(input valid, action, capture_count, output ready);
endinterface

@@ sv/urc_out_if.sv @@
// Output channel: range results with valid/ready.
// No dependencies.
interface urc_out_if;
	logic        valid;
	logic        ready;
	logic [23:0] distance_um;
	logic [31:0] elapsed_us;
	logic [1:0]  status;

	modport source(output valid, distance_um, elapsed_us, status, input ready);
	modport sink(input valid, distance_um, elapsed_us, status, output ready);
endinterface

@@ sv/urc_div.sv @@
// Iterative unsigned divider, two quotient bits per cycle, 32-bit dividend, 17-bit divisor.
// Depends on urc_pkg.
module urc_div (
	input  logic              clk,
	input  logic              arst_n,
	input  urc_pkg::div_req_t req,
	output logic              busy,
	output logic              done,
	output logic [31:0]       quotient
);

	logic [31:0] dvd_q;
	logic [16:0] dsr_q;
	logic [16:0] rem_q;
	logic [31:0] quo_q;
	logic [4:0]  cnt_q;
	logic        done_q;

	logic [17:0] t1, t2, r1, r2;
	logic        ge1, ge2;

	always_comb begin
		t1  = {rem_q, dvd_q[31]};
		ge1 = t1 >= {1'b0, dsr_q};
		r1  = ge1 ? (t1 - {1'b0, dsr_q}) : t1;
		t2  = {r1[16:0], dvd_q[30]};
		ge2 = t2 >= {1'b0, dsr_q};
		r2  = ge2 ? (t2 - {1'b0, dsr_q}) : t2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			if (req.start) begin
				cnt_q <= req.steps;
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 5'd1;
			end
			done_q <= !req.start && (cnt_q == 5'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dsr_q <= req.divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (cnt_q != '0) begin
			dvd_q <= {dvd_q[29:0], 2'b00};
			rem_q <= r2[16:0];
			quo_q <= {quo_q[29:0], ge1, ge2};
		end
	end

	assign busy     = (cnt_q != '0);
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

@@ sv/urc_fifo.sv @@
// Small first-in first-out queue between the front and back of the range capture.
// No dependencies.
module urc_fifo #(
	parameter int unsigned DEPTH = 2,
	parameter int unsigned WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             not_empty
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_q, rd_q;
	logic [CW-1:0]    cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	assign full      = (cnt_q == CW'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign pop_data  = mem_q[rd_q];

endmodule

@@ sv/urc_front.sv @@
// Front end: takes timer events, tracks edge phase and overflows, forms the tick difference.
// Depends on urc_in_if.
module urc_front (
	input  logic        clk,
	input  logic        arst_n,
	urc_in_if.sink      evt,
	input  logic [31:0] auto_reload,
	output logic        push,
	output logic [31:0] push_diff,
	input  logic        full
);

	logic        awaiting_q;
	logic [31:0] start_q;
	logic [15:0] ovf_q;

	logic        valid_s1;
	logic [31:0] cap_s1, prod_s1, start_s1;

	logic        take, load;
	logic [31:0] span;
	logic [47:0] span_prod;
	logic [31:0] end_w;

	assign evt.ready = !valid_s1 || !full;
	assign take      = evt.valid && evt.ready;
	assign load      = take && evt.action && awaiting_q;
	assign span      = auto_reload + 32'd1;
	assign span_prod = ovf_q * span;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaiting_q <= 1'b0;
			start_q    <= '0;
			ovf_q      <= '0;
			valid_s1   <= 1'b0;
		end else begin
			if (take) begin
				if (!evt.action) begin
					ovf_q <= ovf_q + 16'd1;
				end else if (!awaiting_q) begin
					start_q    <= evt.capture_count;
					ovf_q      <= '0;
					awaiting_q <= 1'b1;
				end else begin
					awaiting_q <= 1'b0;
				end
			end
			if (load) begin
				valid_s1 <= 1'b1;
			end else if (push) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// Snapshot the end capture, overflow product and start count so a rising edge right behind cannot disturb them.
	always_ff @(posedge clk) begin
		if (load) begin
			cap_s1   <= evt.capture_count;
			prod_s1  <= span_prod[31:0];
			start_s1 <= start_q;
		end
	end

	assign end_w     = cap_s1 + prod_s1;
	assign push_diff = (end_w > start_s1) ? (end_w - start_s1) : (start_s1 - end_w);
	assign push      = valid_s1 && !full;

endmodule

@@ sv/urc_back.sv @@
// Back end: converts a tick difference to microseconds and micrometres, holds the result.
// Depends on urc_pkg, urc_out_if, urc_div and assert_macros.svh.
`include "assert_macros.svh"

module urc_back (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        fifo_valid,
	input  logic [31:0] fifo_diff,
	output logic        pop,
	input  logic [7:0]  clock_mhz,
	input  logic [15:0] prescaler,
	input  logic [15:0] limit_us,
	urc_out_if.source   res
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_TICKS,
		S_ELAP,
		S_DIST,
		S_EMIT
	} state_t;

	state_t            state_q;
	urc_pkg::div_req_t req_q;
	logic              div_busy, div_done;
	logic [31:0]       div_quo;

	logic [31:0] diff_q, prod_q, pend_el_q;
	logic [7:0]  ticks_q;
	logic [23:0] pend_dist_q;
	logic [1:0]  pend_status_q;

	logic        out_valid_q;
	logic [23:0] out_dist_q;
	logic [31:0] out_el_q;
	logic [1:0]  out_status_q;

	logic [39:0] scaled;
	logic        emit;
	logic        fault_res;

	assign scaled    = fifo_diff * urc_pkg::UM_PER_TICK_US;
	assign pop       = (state_q == S_IDLE) && fifo_valid;
	assign emit      = (state_q == S_EMIT) && (!out_valid_q || res.ready);
	assign fault_res = res.valid && (res.status != urc_pkg::STATUS_VALID);

	urc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_q),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			req_q         <= '0;
			diff_q        <= '0;
			prod_q        <= '0;
			ticks_q       <= '0;
			pend_el_q     <= '0;
			pend_dist_q   <= '0;
			pend_status_q <= '0;
			out_valid_q   <= 1'b0;
			out_dist_q    <= '0;
			out_el_q      <= '0;
			out_status_q  <= '0;
		end else begin
			if (emit) begin
				out_valid_q  <= 1'b1;
				out_dist_q   <= pend_dist_q;
				out_el_q     <= pend_el_q;
				out_status_q <= pend_status_q;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					req_q.start <= fifo_valid;
					if (fifo_valid) begin
						diff_q         <= fifo_diff;
						// Only used when the reading is valid, where it stays below 2^32.
						prod_q         <= scaled[31:0];
						req_q.dividend <= {clock_mhz, 24'd0};
						req_q.divisor  <= 17'(prescaler) + 17'd1;
						req_q.steps    <= urc_pkg::DIV_STEPS_TICKS;
						state_q        <= S_TICKS;
					end
				end
				S_TICKS: begin
					req_q.start <= div_done && (div_quo[7:0] != '0);
					if (div_done) begin
						if (div_quo[7:0] == '0) begin
							pend_dist_q   <= '0;
							pend_el_q     <= '0;
							pend_status_q <= urc_pkg::STATUS_NO_TICKS;
							state_q       <= S_EMIT;
						end else begin
							ticks_q        <= div_quo[7:0];
							req_q.dividend <= diff_q;
							req_q.divisor  <= {9'd0, div_quo[7:0]};
							req_q.steps    <= urc_pkg::DIV_STEPS_WORD;
							state_q        <= S_ELAP;
						end
					end
				end
				S_ELAP: begin
					req_q.start <= div_done && (div_quo <= {16'd0, limit_us});
					if (div_done) begin
						pend_el_q <= div_quo;
						if (div_quo > {16'd0, limit_us}) begin
							pend_dist_q   <= '0;
							pend_status_q <= urc_pkg::STATUS_TIMEOUT;
							state_q       <= S_EMIT;
						end else begin
							req_q.dividend <= prod_q;
							req_q.divisor  <= {9'd0, ticks_q};
							req_q.steps    <= urc_pkg::DIV_STEPS_WORD;
							state_q        <= S_DIST;
						end
					end
				end
				S_DIST: begin
					req_q.start <= 1'b0;
					if (div_done) begin
						pend_dist_q   <= div_quo[23:0];
						pend_status_q <= urc_pkg::STATUS_VALID;
						state_q       <= S_EMIT;
					end
				end
				S_EMIT: begin
					req_q.start <= 1'b0;
					// Hold until the output register is free.
					if (emit) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					req_q.start <= 1'b0;
					state_q     <= S_IDLE;
				end
			endcase
		end
	end

	assign res.valid       = out_valid_q;
	assign res.distance_um = out_dist_q;
	assign res.elapsed_us  = out_el_q;
	assign res.status      = out_status_q;

	`URC_ASSERT(a_div_start_idle, req_q.start |-> !div_busy, "divider started while busy")
	`URC_ASSERT(a_result_from_emit, $rose(res.valid) |-> $past(emit), "result without emit")
	`URC_ASSERT_NEVER(a_fault_zero_dist, fault_res && res.distance_um != '0, "fault with distance")

endmodule

@@ sv/ultrasonic_echo_range_capture_core.sv @@
// Channel | Dir | Handshake   | Payload
// evt     | in  | valid/ready | action, capture_count
// res     | out | valid/ready | distance_um, elapsed_us, status
// cfg     | in  | cfg_we      | cfg_index, cfg_data (write only)
//
// The front end accepts overflow and rising-edge events unless its result waits on a full queue.
// A falling edge holds the back end for three divisions of 4, 16 and 16 radix-4 divider steps
// (tick rate, microseconds, micrometres) plus control; a timeout skips the last, no ticks the last two.
// A queue of FIFO_DEPTH tick differences sits between front and back.
// arst_n clears phase, counts and configuration to their reset values.
// A waiting result stalls the back end only; the front keeps taking events until the queue fills.
//
// Top level of the ultrasonic echo range capture. Depends on urc_pkg, the channel
// interfaces, urc_front, urc_fifo and urc_back.
module ultrasonic_echo_range_capture_core #(
	parameter int unsigned FIFO_DEPTH = urc_pkg::FIFO_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	urc_in_if.sink      evt,
	urc_out_if.source   res,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	logic [31:0] auto_reload_q;
	logic [7:0]  clock_mhz_q;
	logic [15:0] prescaler_q;
	logic [15:0] limit_us_q;

	logic        push, full, pop, fifo_valid;
	logic [31:0] push_diff, fifo_diff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			auto_reload_q <= urc_pkg::AUTO_RELOAD_RST;
			clock_mhz_q   <= urc_pkg::CLOCK_MHZ_RST;
			prescaler_q   <= urc_pkg::PRESCALER_RST;
			limit_us_q    <= urc_pkg::LIMIT_US_RST;
		end else if (cfg_we) begin
			unique case (urc_pkg::cfg_idx_t'(cfg_index))
				urc_pkg::CFG_AUTO_RELOAD: auto_reload_q <= cfg_data;
				urc_pkg::CFG_CLOCK_MHZ:   clock_mhz_q   <= cfg_data[7:0];
				urc_pkg::CFG_PRESCALER:   prescaler_q   <= cfg_data[15:0];
				urc_pkg::CFG_LIMIT_US:    limit_us_q    <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	urc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.evt         (evt),
		.auto_reload (auto_reload_q),
		.push        (push),
		.push_diff   (push_diff),
		.full        (full)
	);

	urc_fifo #(
		.DEPTH (FIFO_DEPTH),
		.WIDTH (32)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_diff),
		.full      (full),
		.pop       (pop),
		.pop_data  (fifo_diff),
		.not_empty (fifo_valid)
	);

	urc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.fifo_valid (fifo_valid),
		.fifo_diff  (fifo_diff),
		.pop        (pop),
		.clock_mhz  (clock_mhz_q),
		.prescaler  (prescaler_q),
		.limit_us   (limit_us_q),
		.res        (res)
	);

endmodule
